// ===== rtl/sste_pkg.sv =====
// ----------------------------------------------------------------------------
// sste_pkg
// Types, constants and helper functions shared by the swap slot table engine
// and its channel interfaces.
// ----------------------------------------------------------------------------
package sste_pkg;

    // table geometry
    localparam int SLOT_COUNT = 1024;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int ROW_WIDTH  = 32;
    localparam int ROW_COUNT  = SLOT_COUNT / ROW_WIDTH;
    localparam int ROW_IDX_W  = $clog2(ROW_COUNT);
    localparam int COL_W      = $clog2(ROW_WIDTH);

    // field widths
    localparam int PTE_W       = 32;
    localparam int FLAG_W      = 12;
    localparam int FRAME_W     = 20;
    localparam int STATUS_W    = 3;
    localparam int SLOT_USED_W = 10;
    localparam int POS_W       = 4;

    // swapped bit position saturates at the top flag bit
    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(FLAG_W - 1);
    localparam logic [POS_W-1:0] POS_RESET = POS_W'(9);

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic [0:0] REG_SWAPPED_POS = 1'b0;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_PRESENCE    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_SLOT     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_SWAPPED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_BAD_SLOT    = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_NO_MEMORY   = 3'd5;

    // request mode
    localparam logic MODE_SWAP_OUT = 1'b0;
    localparam logic MODE_SWAP_IN  = 1'b1;

    typedef logic [ROW_WIDTH-1:0] row_t;

    // index of the lowest set bit, zero when none is set
    function automatic logic [COL_W-1:0] lowest_set(input row_t v);
        logic [COL_W-1:0] idx;
        idx = '0;
        for (int i = ROW_WIDTH - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = COL_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/sste_req_if.sv =====
// ----------------------------------------------------------------------------
// sste_req_if
// Request channel of the swap slot table engine: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface sste_req_if;
    import sste_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic               entry_exists;
    logic [PTE_W-1:0]   pte_in;
    logic [FRAME_W-1:0] new_frame;
    logic               frame_ok;

    modport source (
        output valid, mode, entry_exists, pte_in, new_frame, frame_ok,
        input  ready
    );

    modport sink (
        input  valid, mode, entry_exists, pte_in, new_frame, frame_ok,
        output ready
    );
endinterface

// ===== rtl/sste_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sste_rsp_if
// Result channel of the swap slot table engine: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface sste_rsp_if;
    import sste_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [PTE_W-1:0]       pte_out;
    logic [SLOT_USED_W-1:0] slot_used;
    logic [FRAME_W-1:0]     old_frame;

    modport source (
        output valid, status, pte_out, slot_used, old_frame,
        input  ready
    );

    modport sink (
        input  valid, status, pte_out, slot_used, old_frame,
        output ready
    );
endinterface

// ===== rtl/swap_slot_table_engine.sv =====
// ----------------------------------------------------------------------------
// swap_slot_table_engine
// Swap slot allocator: claims the lowest free slot on swap-out and saves the
// entry flags, restores the entry and releases the slot on swap-in.
// ----------------------------------------------------------------------------
// Flow: a request beat taken in S_IDLE passes S_CHECK, S_EVAL and S_RESP; S_RESP
// registers the result once the output register is free. A failed presence, swapped,
// range or free-slot check in S_CHECK skips S_EVAL. No new request is taken until the
// result is registered; the free map is 32-bit rows behind a per-row summary, and one
// lowest-set-bit finder serves both. Reset: a pass through S_CLEAR sets every free-map
// row to all free; req.ready stays low meanwhile, configuration writes are taken as ever.
module swap_slot_table_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    sste_req_if.sink                        req,
    sste_rsp_if.source                      rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sste_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sste_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sste_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import sste_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_EVAL,
        S_RESP
    } state_t;

    // control and payload registers
    state_t                 state_reg,     state_next;
    logic [ROW_IDX_W-1:0]   clr_cnt_reg,   clr_cnt_next;
    logic [ROW_COUNT-1:0]   summary_reg,   summary_next;
    logic [POS_W-1:0]       pos_reg,       pos_next;
    logic                   mode_reg,      mode_next;
    logic                   exists_reg,    exists_next;
    logic [PTE_W-1:0]       pte_reg,       pte_next;
    logic [FRAME_W-1:0]     frame_reg,     frame_next;
    logic                   frame_ok_reg,  frame_ok_next;
    logic [ROW_IDX_W-1:0]   row_reg,       row_next;
    logic [SLOT_W-1:0]      slot_reg,      slot_next;
    logic [STATUS_W-1:0]    res_st_reg,    res_st_next;
    logic [PTE_W-1:0]       res_pte_reg,   res_pte_next;
    logic [SLOT_USED_W-1:0] res_slot_reg,  res_slot_next;
    logic [FRAME_W-1:0]     res_frame_reg, res_frame_next;
    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    out_st_reg,    out_st_next;
    logic [PTE_W-1:0]       out_pte_reg,   out_pte_next;
    logic [SLOT_USED_W-1:0] out_slot_reg,  out_slot_next;
    logic [FRAME_W-1:0]     out_frame_reg, out_frame_next;

    // memories
    row_t                   free_mem  [ROW_COUNT];
    logic [FLAG_W-1:0]      flags_mem [SLOT_COUNT];
    row_t                   free_rd_reg;
    logic [FLAG_W-1:0]      flags_rd_reg;

    logic                   free_we;
    logic [ROW_IDX_W-1:0]   free_waddr;
    row_t                   free_wdata;
    logic                   free_re;
    logic [ROW_IDX_W-1:0]   free_raddr;
    logic                   flags_we;
    logic                   flags_re;
    logic [SLOT_W-1:0]      flags_addr;

    // shared lowest-free finder and helpers
    row_t                   scan_in;
    logic [COL_W-1:0]       scan_idx;
    logic [POS_W-1:0]       pos_sat;
    logic [FLAG_W-1:0]      swp_mask;
    logic [FRAME_W-1:0]     slot_field;
    logic [COL_W-1:0]       col;
    logic [SLOT_W-1:0]      out_slot;
    logic [FLAG_W-1:0]      out_flags;
    row_t                   col_bit;
    logic                   cfg_wr;
    logic                   req_beat;
    logic                   rsp_beat;

    assign pos_sat    = (pos_reg > POS_MAX) ? POS_MAX : pos_reg;
    assign swp_mask   = FLAG_W'(1) << pos_sat;
    assign slot_field = pte_reg[PTE_W-1:FLAG_W];
    assign scan_in    = (state_reg == S_CHECK) ? ROW_WIDTH'(summary_reg) : free_rd_reg;
    assign scan_idx   = lowest_set(scan_in);
    assign col        = (mode_reg == MODE_SWAP_IN) ? slot_reg[COL_W-1:0] : scan_idx;
    assign col_bit    = ROW_WIDTH'(1) << col;
    assign out_slot   = {row_reg, scan_idx};
    assign out_flags  = (pte_reg[FLAG_W-1:0] & ~FLAG_W'(1)) | swp_mask;

    // handshakes
    assign req.ready  = (state_reg == S_IDLE);
    assign req_beat   = req.valid && req.ready;
    assign rsp_beat   = out_valid_reg && rsp.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_st_reg;
    assign rsp.pte_out   = out_pte_reg;
    assign rsp.slot_used = out_slot_reg;
    assign rsp.old_frame = out_frame_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == REG_SWAPPED_POS);
    assign prdata = (paddr[2:2] == REG_SWAPPED_POS) ? APB_DATA_W'(pos_reg) : '0;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        summary_next   = summary_reg;
        pos_next       = cfg_wr ? pwdata[POS_W-1:0] : pos_reg;
        mode_next      = mode_reg;
        exists_next    = exists_reg;
        pte_next       = pte_reg;
        frame_next     = frame_reg;
        frame_ok_next  = frame_ok_reg;
        row_next       = row_reg;
        slot_next      = slot_reg;
        res_st_next    = res_st_reg;
        res_pte_next   = res_pte_reg;
        res_slot_next  = res_slot_reg;
        res_frame_next = res_frame_reg;
        out_valid_next = out_valid_reg && !rsp_beat;
        out_st_next    = out_st_reg;
        out_pte_next   = out_pte_reg;
        out_slot_next  = out_slot_reg;
        out_frame_next = out_frame_reg;

        free_we    = 1'b0;
        free_waddr = row_reg;
        free_wdata = free_rd_reg;
        free_re    = 1'b0;
        free_raddr = row_reg;
        flags_we   = 1'b0;
        flags_re   = 1'b0;
        flags_addr = slot_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                // mark one row all free per cycle
                free_we      = 1'b1;
                free_waddr   = clr_cnt_reg;
                free_wdata   = '1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ROW_IDX_W'(ROW_COUNT - 1)) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_beat) begin
                    mode_next     = req.mode;
                    exists_next   = req.entry_exists;
                    pte_next      = req.pte_in;
                    frame_next    = req.new_frame;
                    frame_ok_next = req.frame_ok;
                    state_next    = S_CHECK;
                end
            end

            S_CHECK:
            begin
                res_pte_next   = '0;
                res_slot_next  = '0;
                res_frame_next = '0;
                state_next     = S_RESP;
                if (mode_reg == MODE_SWAP_OUT) begin
                    if (!exists_reg || !pte_reg[0]) begin
                        res_st_next = STAT_PRESENCE;
                    end else if (summary_reg == '0) begin
                        res_st_next = STAT_NO_SLOT;
                    end else begin
                        // first row holding a free slot
                        row_next   = scan_idx[ROW_IDX_W-1:0];
                        free_re    = 1'b1;
                        free_raddr = scan_idx[ROW_IDX_W-1:0];
                        state_next = S_EVAL;
                    end
                end else begin
                    if (!exists_reg || pte_reg[0]) begin
                        res_st_next = STAT_PRESENCE;
                    end else if ((pte_reg[FLAG_W-1:0] & swp_mask) == '0) begin
                        res_st_next = STAT_NOT_SWAPPED;
                    end else if (slot_field >= FRAME_W'(SLOT_COUNT)) begin
                        res_st_next = STAT_BAD_SLOT;
                    end else begin
                        row_next   = slot_field[SLOT_W-1:COL_W];
                        slot_next  = slot_field[SLOT_W-1:0];
                        free_re    = 1'b1;
                        free_raddr = slot_field[SLOT_W-1:COL_W];
                        flags_re   = 1'b1;
                        flags_addr = slot_field[SLOT_W-1:0];
                        state_next = S_EVAL;
                    end
                end
            end

            S_EVAL:
            begin
                state_next     = S_RESP;
                res_pte_next   = '0;
                res_slot_next  = '0;
                res_frame_next = '0;
                if (mode_reg == MODE_SWAP_OUT) begin
                    // claim lowest free slot of the row and save the flags
                    free_we        = 1'b1;
                    free_wdata     = free_rd_reg & ~col_bit;
                    summary_next[row_reg] = |(free_rd_reg & ~col_bit);
                    flags_we       = 1'b1;
                    flags_addr     = out_slot;
                    res_st_next    = STAT_OK;
                    res_pte_next   = {FRAME_W'(out_slot), out_flags};
                    res_slot_next  = SLOT_USED_W'(out_slot);
                    res_frame_next = pte_reg[PTE_W-1:FLAG_W];
                end else begin
                    if (free_rd_reg[col]) begin
                        res_st_next = STAT_BAD_SLOT;
                    end else if (!frame_ok_reg) begin
                        res_st_next = STAT_NO_MEMORY;
                    end else begin
                        // release the slot and restore the entry
                        free_we               = 1'b1;
                        free_wdata            = free_rd_reg | col_bit;
                        summary_next[row_reg] = 1'b1;
                        res_st_next           = STAT_OK;
                        res_pte_next  = {frame_reg, flags_rd_reg | FLAG_W'(1)};
                        res_slot_next = SLOT_USED_W'(slot_reg);
                    end
                end
            end

            S_RESP:
            begin
                // hand the result to the output register once it is free
                if (!out_valid_reg || rsp_beat) begin
                    out_valid_next = 1'b1;
                    out_st_next    = res_st_reg;
                    out_pte_next   = res_pte_reg;
                    out_slot_next  = res_slot_reg;
                    out_frame_next = res_frame_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            summary_reg   <= '1;
            pos_reg       <= POS_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            summary_reg   <= summary_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        exists_reg    <= exists_next;
        pte_reg       <= pte_next;
        frame_reg     <= frame_next;
        frame_ok_reg  <= frame_ok_next;
        row_reg       <= row_next;
        slot_reg      <= slot_next;
        res_st_reg    <= res_st_next;
        res_pte_reg   <= res_pte_next;
        res_slot_reg  <= res_slot_next;
        res_frame_reg <= res_frame_next;
        out_st_reg    <= out_st_next;
        out_pte_reg   <= out_pte_next;
        out_slot_reg  <= out_slot_next;
        out_frame_reg <= out_frame_next;
    end

    // free map rows
    always_ff @(posedge clk)
    begin
        if (free_we) begin
            free_mem[free_waddr] <= free_wdata;
        end
        if (free_re) begin
            free_rd_reg <= free_mem[free_raddr];
        end
    end

    // saved flags per slot
    always_ff @(posedge clk)
    begin
        if (flags_we) begin
            flags_mem[flags_addr] <= pte_reg[FLAG_W-1:0];
        end
        if (flags_re) begin
            flags_rd_reg <= flags_mem[flags_addr];
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the swap slot table engine. Request beats are
// mirrored into a scoreboard that keeps its own free map and saved flags and
// works out each expected result; every result beat is compared field by
// field. A directed opening covers the presence, not-swapped, bad-slot and
// no-memory codes and edge positions of the swapped bit. Random traffic
// follows in three phases (mixed, fill-to-full, drain), each under its own
// swapped-bit setting, with bursty requests and a stalling result side.
// ----------------------------------------------------------------------------
module testbench;
    import sste_pkg::*;

    typedef struct {
        logic               mode;
        logic               entry_exists;
        logic [PTE_W-1:0]   pte_in;
        logic [FRAME_W-1:0] new_frame;
        logic               frame_ok;
    } swap_request_t;

    typedef struct {
        logic [STATUS_W-1:0]    status;
        logic [PTE_W-1:0]       pte_out;
        logic [SLOT_USED_W-1:0] slot_used;
        logic [FRAME_W-1:0]     old_frame;
    } swap_result_t;

    localparam logic [APB_ADDR_W-1:0] POS_REG_ADDR = APB_ADDR_W'(4 * int'(REG_SWAPPED_POS));
    localparam int MAX_REPORTS = 100;

    // mirror of the slot table and its expected result beats
    class swap_scoreboard;
        bit                  slot_free [SLOT_COUNT];
        logic [FLAG_W-1:0]   slot_flags [SLOT_COUNT];
        logic [POS_W-1:0]    swapped_pos;
        int                  free_slots;
        int                  errors;
        swap_result_t        pending_results [$];

        function new();
            foreach (slot_free[i])
            begin
                slot_free[i]  = 1'b1;
                slot_flags[i] = '0;
            end
            swapped_pos = POS_RESET;
            free_slots  = SLOT_COUNT;
            errors      = 0;
        endfunction

        // position saturates at the top flag bit
        function logic [PTE_W-1:0] swapped_mask();
            logic [POS_W-1:0] pos;
            pos = (swapped_pos > POS_MAX) ? POS_MAX : swapped_pos;
            return PTE_W'(1) << pos;
        endfunction

        // expected result of one request, applied to the mirrored table
        function swap_result_t predict_swap(swap_request_t r);
            swap_result_t res;
            int           s;
            logic [FRAME_W-1:0] slot_field;
            res.status    = STAT_OK;
            res.pte_out   = '0;
            res.slot_used = '0;
            res.old_frame = '0;
            if (r.mode == MODE_SWAP_OUT)
            begin
                if (!r.entry_exists || !r.pte_in[0])
                begin
                    res.status = STAT_PRESENCE;
                end
                else if (free_slots == 0)
                begin
                    res.status = STAT_NO_SLOT;
                end
                else
                begin
                    for (s = 0; s < SLOT_COUNT; s++)
                    begin
                        if (slot_free[s])
                            break;
                    end
                    slot_flags[s] = r.pte_in[FLAG_W-1:0];
                    slot_free[s]  = 1'b0;
                    free_slots--;
                    res.pte_out    = (PTE_W'(s) << FLAG_W) | PTE_W'(r.pte_in[FLAG_W-1:0]);
                    // present cleared first, swapped set after it
                    res.pte_out[0] = 1'b0;
                    res.pte_out    = res.pte_out | swapped_mask();
                    res.slot_used  = SLOT_USED_W'(s);
                    res.old_frame  = r.pte_in[PTE_W-1:FLAG_W];
                end
            end
            else
            begin
                slot_field = r.pte_in[PTE_W-1:FLAG_W];
                if (!r.entry_exists || r.pte_in[0])
                begin
                    res.status = STAT_PRESENCE;
                end
                else if ((r.pte_in & swapped_mask()) == '0)
                begin
                    res.status = STAT_NOT_SWAPPED;
                end
                else if (int'(slot_field) >= SLOT_COUNT)
                begin
                    res.status = STAT_BAD_SLOT;
                end
                else if (slot_free[int'(slot_field)])
                begin
                    res.status = STAT_BAD_SLOT;
                end
                else if (!r.frame_ok)
                begin
                    res.status = STAT_NO_MEMORY;
                end
                else
                begin
                    s = int'(slot_field);
                    res.pte_out   = {r.new_frame, slot_flags[s] | FLAG_W'(1)};
                    res.slot_used = SLOT_USED_W'(s);
                    slot_free[s]  = 1'b1;
                    slot_flags[s] = '0;
                    free_slots++;
                end
            end
            return res;
        endfunction

        function void note_request(swap_request_t r);
            pending_results.push_back(predict_swap(r));
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                if (errors < MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(swap_result_t got);
            swap_result_t want;
            if (pending_results.size() == 0)
            begin
                if (errors < MAX_REPORTS)
                    $display("%0t: result beat with none expected, status %0d pte_out %h",
                             $time, got.status, got.pte_out);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("status", 32'(want.status), 32'(got.status));
                compare_field("pte_out", want.pte_out, got.pte_out);
                compare_field("slot_used", 32'(want.slot_used), 32'(got.slot_used));
                compare_field("old_frame", 32'(want.old_frame), 32'(got.old_frame));
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sste_req_if req_ch ();
    sste_rsp_if rsp_ch ();

    swap_scoreboard sb;
    int             burst_left;
    int             seg_left;
    int             seg_kind;

    swap_slot_table_engine dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // result side stalls in segments: always ready, coin toss, mostly stalled
    always @(negedge clk)
    begin
        if (seg_left == 0)
        begin
            seg_kind = $urandom_range(0, 2);
            seg_left = $urandom_range(1, 60);
        end
        seg_left--;
        case (seg_kind)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 1) == 1);
            default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // result beat monitor
    always @(posedge clk)
    begin
        swap_result_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.status    = rsp_ch.status;
            got.pte_out   = rsp_ch.pte_out;
            got.slot_used = rsp_ch.slot_used;
            got.old_frame = rsp_ch.old_frame;
            sb.check_result(got);
        end
    end

    // one request beat, then the burst/gap pacing
    task automatic send_item(input swap_request_t it);
        int gap;
        req_ch.mode         <= it.mode;
        req_ch.entry_exists <= it.entry_exists;
        req_ch.pte_in       <= it.pte_in;
        req_ch.new_frame    <= it.new_frame;
        req_ch.frame_ok     <= it.frame_ok;
        req_ch.valid        <= 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(it);
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 12);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(0, 30);
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic send_fields(input logic m, input logic e, input logic [PTE_W-1:0] p,
                               input logic [FRAME_W-1:0] f, input logic ok);
        swap_request_t it;
        it.mode         = m;
        it.entry_exists = e;
        it.pte_in       = p;
        it.new_frame    = f;
        it.frame_ok     = ok;
        send_item(it);
    endtask

    // stop requests and wait for every outstanding result
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    // apb write: setup then access, taken when pready is high
    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.swapped_pos = data[POS_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // a busy slot from a random start, or a free one if the table is empty
    function automatic int pick_busy_slot();
        int start;
        int s;
        start = $urandom_range(0, SLOT_COUNT - 1);
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            s = (start + i) % SLOT_COUNT;
            if (!sb.slot_free[s])
                return s;
        end
        return start;
    endfunction

    // mostly well-formed swap-outs and swap-ins, the rest noise
    function automatic swap_request_t random_request(input int out_pct, input int in_pct);
        swap_request_t it;
        int            r;
        int            slot;
        r = $urandom_range(0, 99);
        it.mode         = MODE_SWAP_OUT;
        it.entry_exists = 1'b1;
        it.pte_in       = $urandom;
        it.new_frame    = FRAME_W'($urandom);
        it.frame_ok     = 1'b1;
        if (r < out_pct)
        begin
            it.pte_in[0] = 1'b1;
            it.frame_ok  = ($urandom_range(0, 1) == 1);
        end
        else if (r < out_pct + in_pct)
        begin
            slot         = pick_busy_slot();
            it.mode      = MODE_SWAP_IN;
            it.pte_in    = {FRAME_W'(slot), FLAG_W'($urandom)};
            it.pte_in[0] = 1'b0;
            it.pte_in    = it.pte_in | sb.swapped_mask();
            it.frame_ok  = ($urandom_range(0, 9) != 0);
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    // every field random
                    it.mode         = ($urandom_range(0, 1) == 1);
                    it.entry_exists = ($urandom_range(0, 1) == 1);
                    it.frame_ok     = ($urandom_range(0, 1) == 1);
                end
                1:
                begin
                    // swap-in with a random, mostly out-of-range slot field
                    it.mode      = MODE_SWAP_IN;
                    it.pte_in[0] = 1'b0;
                    it.pte_in    = it.pte_in | sb.swapped_mask();
                    it.frame_ok  = ($urandom_range(0, 1) == 1);
                end
                default:
                begin
                    // broken presence on either mode
                    it.mode         = ($urandom_range(0, 1) == 1);
                    it.entry_exists = ($urandom_range(0, 1) == 1);
                    it.pte_in[0]    = (it.mode == MODE_SWAP_IN);
                end
            endcase
        end
        return it;
    endfunction

    initial
    begin
        int extra;
        sb         = new();
        burst_left = 0;
        seg_left   = 0;
        seg_kind   = 0;

        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_ch.valid        = 1'b0;
        req_ch.mode         = MODE_SWAP_OUT;
        req_ch.entry_exists = 1'b0;
        req_ch.pte_in       = '0;
        req_ch.new_frame    = '0;
        req_ch.frame_ok     = 1'b0;
        rsp_ch.ready        = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, swapped bit at its reset position
        send_fields(MODE_SWAP_OUT, 1'b0, 32'hFFFF_FFFF, 20'h00000, 1'b1);
        send_fields(MODE_SWAP_OUT, 1'b1, 32'hFFFF_F000, 20'hFFFFF, 1'b0);
        send_fields(MODE_SWAP_OUT, 1'b1, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1);
        send_fields(MODE_SWAP_OUT, 1'b1, 32'h0000_0001, 20'h00000, 1'b0);
        send_fields(MODE_SWAP_IN,  1'b0, 32'h0000_0200, 20'h12345, 1'b1);
        send_fields(MODE_SWAP_IN,  1'b1, 32'h0000_0201, 20'h12345, 1'b1);
        send_fields(MODE_SWAP_IN,  1'b1, 32'h0000_0000, 20'h12345, 1'b1);
        send_fields(MODE_SWAP_IN,  1'b1, 32'hFFFF_F200, 20'h12345, 1'b1);
        send_fields(MODE_SWAP_IN,  1'b1, 32'h0040_0200, 20'h12345, 1'b1);
        send_fields(MODE_SWAP_IN,  1'b1, 32'h003F_F200, 20'h12345, 1'b1);
        send_fields(MODE_SWAP_IN,  1'b1, 32'h0000_5200, 20'h12345, 1'b1);
        send_fields(MODE_SWAP_IN,  1'b1, 32'h0000_0200, 20'hFFFFF, 1'b0);
        send_fields(MODE_SWAP_IN,  1'b1, 32'h0000_0200, 20'hFFFFF, 1'b1);
        send_fields(MODE_SWAP_IN,  1'b1, 32'h0000_1200, 20'h00000, 1'b1);
        send_fields(MODE_SWAP_IN,  1'b1, 32'h0000_0200, 20'hABCDE, 1'b1);
        send_fields(MODE_SWAP_OUT, 1'b1, 32'h0000_0001, 20'h54321, 1'b1);
        settle();

        // swapped bit on top of the present bit
        write_reg(POS_REG_ADDR, 32'd0);
        send_fields(MODE_SWAP_OUT, 1'b1, 32'h1234_5001, 20'h00000, 1'b1);
        send_fields(MODE_SWAP_IN,  1'b1, 32'h0000_1001, 20'h00001, 1'b1);
        send_fields(MODE_SWAP_IN,  1'b1, 32'h0000_1000, 20'h00001, 1'b1);
        settle();

        // position above the flag field saturates
        write_reg(POS_REG_ADDR, 32'd15);
        send_fields(MODE_SWAP_OUT, 1'b1, 32'h8765_4FFF, 20'h00000, 1'b1);
        send_fields(MODE_SWAP_IN,  1'b1, 32'h0000_2000 | 32'h0000_8000, 20'h00002, 1'b1);
        send_fields(MODE_SWAP_IN,  1'b1, 32'h0000_2800, 20'h00002, 1'b1);
        settle();

        // mixed traffic, with one full drain part-way through
        write_reg(POS_REG_ADDR, APB_DATA_W'($urandom_range(1, 10)));
        for (int i = 0; i < 300; i++)
        begin
            if (i == 150)
                settle();
            send_item(random_request(50, 35));
        end
        settle();

        // fill the table and keep asking past full
        write_reg(POS_REG_ADDR, 32'd11);
        extra = 0;
        while (extra < 12)
        begin
            if (sb.free_slots == 0)
                extra++;
            send_item(random_request(90, 5));
        end
        settle();

        // drain with swap-ins dominating
        write_reg(POS_REG_ADDR, APB_DATA_W'($urandom_range(1, 15)));
        for (int i = 0; i < 400; i++)
            send_item(random_request(25, 60));
        settle();

        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
